FILE: rtl/euler_xyz_to_quaternion_macros.svh
// Assertion macros for the Euler to quaternion block.
`ifndef EULER_XYZ_TO_QUATERNION_MACROS_SVH
`define EULER_XYZ_TO_QUATERNION_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EQ_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EQ_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> expr) else $error(msg);
`else
`define EQ_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define EQ_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg)
`endif
`endif

FILE: rtl/eulq_pkg.sv
// ----------------------------------------------------------------------------
// eulq_pkg
// Shared constants and types for the Euler XYZ to quaternion pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package eulq_pkg;
    // Number of CORDIC micro-rotations, between 8 and 24.
    localparam int CORDIC_STEPS = 16;
    localparam int CW = 34;   // CORDIC datapath width (Q2.30 plus headroom)
    localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [15:0]   Q14_MAX     = 16'sd16384;

    typedef logic signed [CW-1:0] t_cw;

    // Arctangent of 2^-i in Q30.
    function automatic t_cw atan_q30(input int i);
        t_cw r;
        case (i)
            0: r = 34'sd843314857;   1: r = 34'sd497837830;
            2: r = 34'sd263043837;   3: r = 34'sd133525159;
            4: r = 34'sd67021687;    5: r = 34'sd33543516;
            6: r = 34'sd16775851;    7: r = 34'sd8388437;
            8: r = 34'sd4194283;     9: r = 34'sd2097149;
            10: r = 34'sd1048576;    11: r = 34'sd524288;
            12: r = 34'sd262144;     13: r = 34'sd131072;
            14: r = 34'sd65536;      15: r = 34'sd32768;
            16: r = 34'sd16384;      17: r = 34'sd8192;
            18: r = 34'sd4096;       19: r = 34'sd2048;
            20: r = 34'sd1024;       21: r = 34'sd512;
            22: r = 34'sd256;        default: r = 34'sd128;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/eulq_cordic.sv
// ----------------------------------------------------------------------------
// eulq_cordic
// Unrolled, pipelined half-angle sine and cosine: range fold stage, then one
// register stage per micro-rotation, then the sign correction stage.
// ----------------------------------------------------------------------------
`default_nettype none
module eulq_cordic import eulq_pkg::*; (
    input  wire         i_clk,
    input  wire         i_en,
    input  wire  [15:0] i_angle,
    output logic signed [CW-1:0] o_cos,
    output logic signed [CW-1:0] o_sin
);
    t_cw r_x [0:CORDIC_STEPS];
    t_cw r_y [0:CORDIC_STEPS];
    t_cw r_z [0:CORDIC_STEPS];
    logic r_neg [0:CORDIC_STEPS];
    t_cw n_z0;
    logic n_neg0;

    // Halve the angle into Q30 and fold it into plus or minus pi/2.
    always_comb begin
        t_cw za;
        za = t_cw'(signed'(i_angle)) <<< 17;
        n_z0 = za;
        n_neg0 = 1'b0;
        if (za > Q30_HALF_PI) begin
            n_z0 = za - Q30_PI;
            n_neg0 = 1'b1;
        end else if (za < -Q30_HALF_PI) begin
            n_z0 = za + Q30_PI;
            n_neg0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_GAIN;
            r_y[0] <= '0;
            r_z[0] <= n_z0;
            r_neg[0] <= n_neg0;
        end
    end

    // One micro-rotation per stage.
    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[g+1] <= r_neg[g];
                if (!r_z[g][CW-1]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_q30(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_q30(g);
                end
            end
        end
    end

    // Undo the fold by negating both results.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_cos <= r_neg[CORDIC_STEPS] ? -r_x[CORDIC_STEPS] : r_x[CORDIC_STEPS];
            o_sin <= r_neg[CORDIC_STEPS] ? -r_y[CORDIC_STEPS] : r_y[CORDIC_STEPS];
        end
    end
endmodule
`default_nettype wire

FILE: rtl/euler_xyz_to_quaternion.sv
// ----------------------------------------------------------------------------
// euler_xyz_to_quaternion
// Converts X, Y, Z Euler angles (Q4.12 rad) to a unit quaternion (Q1.14).
// ----------------------------------------------------------------------------
// Usage: angles arrive on the slave stream (s_axis), one transaction per
// pose; the quaternion leaves on the master stream (m_axis), one transaction
// per input. The pipeline takes a new transaction in every cycle unless the
// output is stalled. The stages are the fold stage, one stage per CORDIC
// micro-rotation, the sign stage, the pair product stage, one stage for the
// component products, one for the sums with rounding, and the output
// register with saturation.
// Throughput is one transaction per cycle while the output does not stall,
// set by the fully unrolled CORDIC and the pipelined multipliers.
// The whole pipeline advances together: when the receiver holds tready low
// with a valid result at the output, every stage freezes and s_axis_tready
// falls, so nothing is lost or repeated. A synchronous active-low reset
// clears every valid bit; the data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "euler_xyz_to_quaternion_macros.svh"
module euler_xyz_to_quaternion import eulq_pkg::*; (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [47:0] s_axis_tdata,  // angle_x[15:0], angle_y[31:16], angle_z[47:32]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [63:0] m_axis_tdata   // quat_w, quat_x, quat_y, quat_z, 16 bits each
);
    localparam int LAT = CORDIC_STEPS + 6;

    logic w_en;
    logic [LAT-1:0] r_vld;
    t_cw cx, sx, cy, sy, cz, sz;

    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAT-1];

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    eulq_cordic u_cx (.i_clk, .i_en(w_en), .i_angle(s_axis_tdata[15:0]),
                      .o_cos(cx), .o_sin(sx));
    eulq_cordic u_cy (.i_clk, .i_en(w_en), .i_angle(s_axis_tdata[31:16]),
                      .o_cos(cy), .o_sin(sy));
    eulq_cordic u_cz (.i_clk, .i_en(w_en), .i_angle(s_axis_tdata[47:32]),
                      .o_cos(cz), .o_sin(sz));

    // Pair products rounded back to Q30; cos and sin of Y delayed to match.
    t_cw r_cc, r_cs, r_sc, r_ss, r_cy, r_sy;
    logic signed [2*CW-1:0] p_cc, p_cs, p_sc, p_ss;
    localparam logic signed [2*CW-1:0] HALF30 = 68'sd536870912;
    assign p_cc = cx * cz + HALF30;
    assign p_cs = cx * sz + HALF30;
    assign p_sc = sx * cz + HALF30;
    assign p_ss = sx * sz + HALF30;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cc <= t_cw'(p_cc >>> 30);
            r_cs <= t_cw'(p_cs >>> 30);
            r_sc <= t_cw'(p_sc >>> 30);
            r_ss <= t_cw'(p_ss >>> 30);
            r_cy <= cy;
            r_sy <= sy;
        end
    end

    // Eight products of the Y terms with the pairs.
    logic signed [2*CW-1:0] r_m [0:7];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m[0] <= r_cy * r_cc;  r_m[1] <= r_sy * r_ss;
            r_m[2] <= r_cy * r_sc;  r_m[3] <= r_sy * r_cs;
            r_m[4] <= r_cy * r_ss;  r_m[5] <= r_sy * r_cc;
            r_m[6] <= r_cy * r_cs;  r_m[7] <= r_sy * r_sc;
        end
    end

    // Sums, rounding to Q14.
    logic signed [2*CW-1:0] r_s [0:3];
    localparam logic signed [2*CW-1:0] HALF46 = 68'sd35184372088832;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s[0] <= (r_m[0] + r_m[1] + HALF46) >>> 46;
            r_s[1] <= (r_m[2] - r_m[3] + HALF46) >>> 46;
            r_s[2] <= (r_m[4] + r_m[5] + HALF46) >>> 46;
            r_s[3] <= (r_m[6] - r_m[7] + HALF46) >>> 46;
        end
    end

    // Saturation to plus or minus one into the output register.
    logic [15:0] n_q [0:3];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            if (r_s[k] > 68'sd16384)       n_q[k] = Q14_MAX;
            else if (r_s[k] < -68'sd16384) n_q[k] = -Q14_MAX;
            else                           n_q[k] = r_s[k][15:0];
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            m_axis_tdata <= {n_q[3], n_q[2], n_q[1], n_q[0]};
        end
    end

    `EQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && m_axis_tvalid, "output changed while stalled")
    `EQ_ASSERT_IMPL(a_ready, i_clk, i_rst_n, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "ready does not follow output stall")
    `EQ_ASSERT_NEXT(a_freeze, i_clk, i_rst_n, !s_axis_tready, $stable(r_vld), "pipeline moved while stalled")
endmodule
`default_nettype wire
